// ----- hw/rtl/nhd_pkg.sv -----
// Package for the escaped name decoder: constants, types and the digit conversion.
// Used by the input stage, decoder, result queue and top level; depends on nothing.
package nhd_pkg;

    localparam logic [7:0] HASH_CHAR     = 8'h23;
    localparam logic [7:0] UPPER_A       = 8'h41;
    localparam logic [7:0] DIGIT_OFFSET  = 8'h30;
    localparam logic [7:0] LETTER_OFFSET = 8'h37;
    localparam logic [7:0] NIBBLE_MASK   = 8'h0F;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    typedef enum logic [1:0] {
        PH_NORMAL     = 2'd0,
        PH_AFTER_HASH = 2'd1,
        PH_AFTER_HIGH = 2'd2
    } nhd_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } nhd_beat_t;

    typedef struct packed {
        logic [1:0] count;
        nhd_beat_t  beat0;
        nhd_beat_t  beat1;
    } nhd_result_t;

    function automatic logic [7:0] digit_value(input logic [7:0] d);
        logic [7:0] off;
        off = (d < UPPER_A) ? DIGIT_OFFSET : LETTER_OFFSET;
        return d - off;
    endfunction

endpackage

// ----- hw/rtl/nhd_in_if.sv -----
// Input channel of the escaped name decoder: valid, ready and one escaped byte.
// Depends on nothing.
interface nhd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// ----- hw/rtl/nhd_out_if.sv -----
// Output channel of the escaped name decoder: valid, ready and one decoded byte.
// Depends on nothing.
interface nhd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

// ----- hw/rtl/nhd_in_stage.sv -----
// Input register of the escaped name decoder.
// Depends on nhd_pkg and nhd_in_if.
module nhd_in_stage
    import nhd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    nhd_in_if.sink     in_stream,
    input  logic       take,
    output logic       item_valid,
    output nhd_beat_t  item
);

    logic      valid_reg;
    logic      valid_next;
    nhd_beat_t item_reg;
    logic      load;

    assign in_stream.ready = !valid_reg || take;
    assign load            = in_stream.valid && in_stream.ready;
    assign valid_next      = load || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.data <= in_stream.in_byte;
            item_reg.last <= in_stream.in_last;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- hw/rtl/nhd_decode.sv -----
// Escape decoder: the phase state machine and the held high digit.
// Depends on nhd_pkg.
module nhd_decode
    import nhd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  nhd_beat_t   item,
    input  logic        fire,
    output nhd_result_t res
);

    nhd_phase_t phase_reg;
    nhd_phase_t phase_next;
    logic [7:0] high_reg;
    logic [7:0] high_next;
    logic [7:0] dv;

    always_comb
    begin
        dv         = digit_value(item.data);
        phase_next = PH_NORMAL;
        high_next  = high_reg;
        res        = '0;
        case (phase_reg)
            PH_AFTER_HASH:
            begin
                if (item.last)
                begin
                    res.count      = 2'd2;
                    res.beat0.data = HASH_CHAR;
                    res.beat0.last = 1'b0;
                    res.beat1.data = item.data;
                    res.beat1.last = 1'b1;
                end
                else
                begin
                    high_next  = {dv[3:0], 4'h0};
                    phase_next = PH_AFTER_HIGH;
                end
            end
            PH_AFTER_HIGH:
            begin
                res.count      = 2'd1;
                res.beat0.data = high_reg | (dv & NIBBLE_MASK);
                res.beat0.last = item.last;
            end
            default:
            begin
                if (item.data == HASH_CHAR && !item.last)
                begin
                    phase_next = PH_AFTER_HASH;
                end
                else
                begin
                    res.count      = 2'd1;
                    res.beat0.data = item.data;
                    res.beat0.last = item.last;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_NORMAL;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            high_reg <= high_next;
        end
    end

endmodule

// ----- hw/rtl/nhd_out_fifo.sv -----
// Result queue of the escaped name decoder: takes up to two beats a cycle, gives one while ready.
// Depends on nhd_pkg and nhd_out_if.
module nhd_out_fifo
    import nhd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  nhd_result_t        res,
    output logic [FIFO_CW-1:0] level,
    nhd_out_if.source          out_stream
);

    nhd_beat_t          mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_next;
    logic [FIFO_CW-1:0] level_reg;
    logic [FIFO_CW-1:0] level_next;
    logic [1:0]         push_n;
    logic               pop;

    assign push_n = push ? res.count : 2'd0;
    assign pop    = out_stream.valid && out_stream.ready;

    assign wr_ptr_next = wr_ptr_reg + FIFO_AW'(push_n);
    assign rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
    assign level_next  = level_reg + FIFO_CW'(push_n) - FIFO_CW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= res.beat0;
        end
        if (push_n == 2'd2)
        begin
            mem_reg[wr_ptr_reg + FIFO_AW'(1)] <= res.beat1;
        end
    end

    assign level               = level_reg;
    assign out_stream.valid    = (level_reg != '0);
    assign out_stream.out_byte = mem_reg[rd_ptr_reg].data;
    assign out_stream.out_last = mem_reg[rd_ptr_reg].last;

endmodule

// ----- hw/rtl/name_hex_escape_decoder_core.sv -----
// Top level of the escaped name decoder: input register, decoder and result queue.
// Depends on nhd_pkg, nhd_in_if, nhd_out_if, nhd_in_stage, nhd_decode, nhd_out_fifo.
//
// The block takes an escaped name on in_stream, one byte per beat, with in_last
// on the final byte, and gives the decoded name on out_stream, one byte per beat,
// with out_last on the final decoded byte. A hash followed by two bytes becomes
// one byte; a hash followed by only one byte of the name passes through literally.
// A byte enters the input register at the edge that accepts it; it is decoded and
// queued at an edge at which the result queue has room for its result, and
// out_stream shows the head of that queue straight from the queue's registers.
// The block accepts one byte per cycle while the queue has room; a hash and final
// byte that give two literal beats are queued together, which the four-beat result
// queue absorbs. When the receiver stalls, the queue fills and in_stream.ready drops
// once the queue has no room for the next result; in_stream.ready never depends
// combinationally on out_stream.ready. Reset empties the queue and the input
// register and returns the decoder to plain bytes.
module name_hex_escape_decoder_core
    import nhd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    nhd_in_if.sink    in_stream,
    nhd_out_if.source out_stream
);

    logic               item_valid;
    nhd_beat_t          item;
    nhd_result_t        res;
    logic [FIFO_CW-1:0] level;
    logic               fire;

    assign fire = item_valid && ((level + FIFO_CW'(res.count)) <= FIFO_CW'(FIFO_DEPTH));

    nhd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_stream),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    nhd_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .fire  (fire),
        .res   (res)
    );

    nhd_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (fire),
        .res        (res),
        .level      (level),
        .out_stream (out_stream)
    );

endmodule

// ----- hw/rtl/nhd_checker.sv -----
// Port-level checks for the escaped name decoder, bound to the top level.
// Depends on name_hex_escape_decoder_core.
module nhd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_last,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       out_last
);

    logic [3:0] lasts_reg;
    logic [3:0] lasts_next;
    logic       in_end;
    logic       out_end;

    assign in_end     = in_valid && in_ready && in_last;
    assign out_end    = out_valid && out_ready && out_last;
    assign lasts_next = lasts_reg + 4'(in_end) - 4'(out_end);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lasts_reg <= '0;
        end
        else
        begin
            lasts_reg <= lasts_next;
        end
    end

    // A name can only end on the output after it has ended on the input.
    assert property (@(posedge clk) disable iff (!rst_n) out_end |-> (lasts_reg != 4'd0))
        else $error("final output beat without a pending final input beat");

    // The block never holds more finished names than it has room for.
    assert property (@(posedge clk) disable iff (!rst_n) lasts_reg <= 4'd5)
        else $error("too many names in flight");

    // Reset empties the result queue.
    assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("output valid during reset");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
        else $error("stalled output beat changed");

endmodule

bind name_hex_escape_decoder_core nhd_checker u_nhd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_stream.valid),
    .in_ready  (in_stream.ready),
    .in_last   (in_stream.in_last),
    .out_valid (out_stream.valid),
    .out_ready (out_stream.ready),
    .out_byte  (out_stream.out_byte),
    .out_last  (out_stream.out_last)
);

// ----- test/name_hex_escape_decoder_core_test.sv -----
// Self-checking testbench for name_hex_escape_decoder_core: directed table, then random names.
// Depends on nhd_pkg, nhd_in_if, nhd_out_if and the decoder top level.
module name_hex_escape_decoder_core_test;
    import nhd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET    = 1200;
    localparam int IDLE_PERCENT   = 36;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int DRAIN_CYCLES   = 10;
    localparam int PREDICT        = -1;

    typedef struct {
        logic [7:0] data;
        logic       last;
        int         n_typed;
        nhd_beat_t  r0;
        nhd_beat_t  r1;
    } row_t;

    logic clk;
    logic rst_n;

    nhd_in_if  in_stream ();
    nhd_out_if out_stream ();

    name_hex_escape_decoder_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_stream (in_stream.sink),
        .out_stream(out_stream.source)
    );

    nhd_phase_t phase;
    logic [7:0] held_high;
    nhd_beat_t  decoded_q[$];
    row_t       directed_rows[$];
    logic [7:0] name_bytes[$];
    string      hex_chars = "0123456789ABCDEFabcdef";

    int  error_count;
    int  bytes_sent;
    int  beats_seen;
    int  escapes_decoded;
    int  names_sent;
    int  quiet_cycles;
    bit  steady_in;
    bit  steady_out;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [7:0] digit_weight(input logic [7:0] d);
        logic [7:0] offset;
        offset = (d < UPPER_A) ? DIGIT_OFFSET : LETTER_OFFSET;
        return d - offset;
    endfunction

    function automatic void decode_step(input logic [7:0] d, input logic l, output int n,
                                        output nhd_beat_t r0, output nhd_beat_t r1);
        logic [7:0] w;
        n = 0;
        r0 = '0;
        r1 = '0;
        w = digit_weight(d);
        case (phase)
            PH_AFTER_HASH:
            begin
                if (l)
                begin
                    r0 = '{data: HASH_CHAR, last: 1'b0};
                    r1 = '{data: d, last: 1'b1};
                    n = 2;
                    phase = PH_NORMAL;
                end
                else
                begin
                    held_high = {w[3:0], 4'h0};
                    phase = PH_AFTER_HIGH;
                end
            end
            PH_AFTER_HIGH:
            begin
                r0 = '{data: held_high | (w & NIBBLE_MASK), last: l};
                n = 1;
                escapes_decoded++;
                phase = PH_NORMAL;
            end
            default:
            begin
                if (d == HASH_CHAR && !l)
                begin
                    phase = PH_AFTER_HASH;
                end
                else
                begin
                    r0 = '{data: d, last: l};
                    n = 1;
                    phase = PH_NORMAL;
                end
            end
        endcase
    endfunction

    task automatic add_row(input logic [7:0] d, input logic l, input int n,
                           input logic [7:0] b0, input logic l0,
                           input logic [7:0] b1, input logic l1);
        row_t row;
        row.data = d;
        row.last = l;
        row.n_typed = n;
        row.r0 = '{data: b0, last: l0};
        row.r1 = '{data: b1, last: l1};
        directed_rows = {directed_rows, row};
    endtask

    // A typed expectation replaces the predicted one; the predictor still tracks state.
    task automatic send_byte(input logic [7:0] d, input logic l, input int n_typed,
                             input nhd_beat_t t0, input nhd_beat_t t1);
        int        n;
        nhd_beat_t r0;
        nhd_beat_t r1;
        while (!steady_in && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_stream.valid <= 1'b0;
            @(posedge clk);
        end
        in_stream.valid   <= 1'b1;
        in_stream.in_byte <= d;
        in_stream.in_last <= l;
        @(posedge clk);
        while (!in_stream.ready)
            @(posedge clk);
        decode_step(d, l, n, r0, r1);
        if (n_typed != PREDICT)
        begin
            n = n_typed;
            r0 = t0;
            r1 = t1;
        end
        if (n > 0)
            decoded_q = {decoded_q, r0};
        if (n > 1)
            decoded_q = {decoded_q, r1};
        bytes_sent++;
        if (l)
            names_sent++;
    endtask

    task automatic send_name();
        int i;
        for (i = 0; i < name_bytes.size(); i++)
            send_byte(name_bytes[i], i == name_bytes.size() - 1, PREDICT, '0, '0);
    endtask

    function automatic logic [7:0] random_digit();
        if ($urandom_range(99) < 85)
            return hex_chars[$urandom_range(hex_chars.len() - 1)];
        return 8'($urandom_range(255));
    endfunction

    always @(posedge clk)
    begin
        if (steady_out)
            out_stream.ready <= 1'b1;
        else
            out_stream.ready <= ($urandom_range(99) >= IDLE_PERCENT);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_stream.valid && out_stream.ready)
        begin
            beats_seen++;
            if (decoded_q.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, got out_byte %02h out_last %0b",
                         $time, out_stream.out_byte, out_stream.out_last);
                error_count++;
            end
            else
            begin
                if (out_stream.out_byte !== decoded_q[0].data)
                begin
                    $display("%0t: out_byte expected %02h, got %02h",
                             $time, decoded_q[0].data, out_stream.out_byte);
                    error_count++;
                end
                if (out_stream.out_last !== decoded_q[0].last)
                begin
                    $display("%0t: out_last expected %0b, got %0b",
                             $time, decoded_q[0].last, out_stream.out_last);
                    error_count++;
                end
                void'(decoded_q.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_stream.valid && in_stream.ready)
            || (out_stream.valid && out_stream.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles, %0d beats still expected",
                         $time, quiet_cycles, decoded_q.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        int  len;
        int  i;
        int  r;
        bit  paused;

        rst_n = 1'b0;
        in_stream.valid = 1'b0;
        in_stream.in_byte = 8'h00;
        in_stream.in_last = 1'b0;
        out_stream.ready = 1'b0;
        phase = PH_NORMAL;
        held_high = 8'h00;
        error_count = 0;
        bytes_sent = 0;
        beats_seen = 0;
        escapes_decoded = 0;
        names_sent = 0;
        quiet_cycles = 0;
        steady_in = 1'b0;
        steady_out = 1'b0;
        paused = 1'b0;

        add_row("A",       1'b0, 1,       "A",       1'b0, 8'h00, 1'b0);
        add_row(8'h00,     1'b0, 1,       8'h00,     1'b0, 8'h00, 1'b0);
        add_row(8'hFF,     1'b1, 1,       8'hFF,     1'b1, 8'h00, 1'b0);
        add_row(HASH_CHAR, 1'b0, 0,       8'h00,     1'b0, 8'h00, 1'b0);
        add_row("4",       1'b0, 0,       8'h00,     1'b0, 8'h00, 1'b0);
        add_row("1",       1'b1, 1,       8'h41,     1'b1, 8'h00, 1'b0);
        add_row(HASH_CHAR, 1'b1, 1,       HASH_CHAR, 1'b1, 8'h00, 1'b0);
        add_row("x",       1'b0, PREDICT, 8'h00,     1'b0, 8'h00, 1'b0);
        add_row(HASH_CHAR, 1'b0, PREDICT, 8'h00,     1'b0, 8'h00, 1'b0);
        add_row("Z",       1'b1, 2,       HASH_CHAR, 1'b0, "Z",   1'b1);
        add_row(HASH_CHAR, 1'b0, PREDICT, 8'h00,     1'b0, 8'h00, 1'b0);
        add_row("f",       1'b0, PREDICT, 8'h00,     1'b0, 8'h00, 1'b0);
        add_row("F",       1'b0, PREDICT, 8'h00,     1'b0, 8'h00, 1'b0);
        add_row(HASH_CHAR, 1'b0, PREDICT, 8'h00,     1'b0, 8'h00, 1'b0);
        add_row(8'hFF,     1'b0, PREDICT, 8'h00,     1'b0, 8'h00, 1'b0);
        add_row(8'h00,     1'b0, PREDICT, 8'h00,     1'b0, 8'h00, 1'b0);
        add_row(HASH_CHAR, 1'b0, PREDICT, 8'h00,     1'b0, 8'h00, 1'b0);
        add_row(HASH_CHAR, 1'b0, PREDICT, 8'h00,     1'b0, 8'h00, 1'b0);
        add_row(HASH_CHAR, 1'b0, PREDICT, 8'h00,     1'b0, 8'h00, 1'b0);
        add_row("9",       1'b1, PREDICT, 8'h00,     1'b0, 8'h00, 1'b0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
            send_byte(directed_rows[k].data, directed_rows[k].last, directed_rows[k].n_typed,
                      directed_rows[k].r0, directed_rows[k].r1);

        while (bytes_sent < ITEM_TARGET)
        begin
            steady_in = (bytes_sent >= 300 && bytes_sent < 500);
            steady_out = steady_in;
            if (!paused && bytes_sent >= 700)
            begin
                paused = 1'b1;
                in_stream.valid <= 1'b0;
                @(posedge clk);
                while (decoded_q.size() != 0)
                    @(posedge clk);
            end
            name_bytes.delete();
            len = ($urandom_range(99) < 5) ? $urandom_range(40, 13) : $urandom_range(12, 1);
            r = $urandom_range(99);
            if (r < 80)
            begin
                while (name_bytes.size() < len)
                begin
                    if ($urandom_range(99) < 35)
                    begin
                        name_bytes = {name_bytes, HASH_CHAR};
                        name_bytes = {name_bytes, random_digit()};
                        name_bytes = {name_bytes, random_digit()};
                    end
                    else
                    begin
                        name_bytes = {name_bytes, 8'($urandom_range(255))};
                    end
                end
            end
            else if (r < 92)
            begin
                for (i = 0; i < len - 1; i++)
                    name_bytes = {name_bytes, 8'($urandom_range(255))};
                name_bytes = {name_bytes, HASH_CHAR};
                if ($urandom_range(1))
                    name_bytes = {name_bytes, random_digit()};
            end
            else
            begin
                for (i = 0; i < len; i++)
                    name_bytes = {name_bytes, ($urandom_range(3) == 0) ? HASH_CHAR
                                                                      : 8'($urandom_range(255))};
            end
            send_name();
        end

        steady_in = 1'b0;
        steady_out = 1'b0;
        in_stream.valid <= 1'b0;
        @(posedge clk);
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes in %0d names; checked %0d decoded beats, %0d of them escapes.",
                 bytes_sent, names_sent, beats_seen, escapes_decoded);
        $display("Both sides idled at random, with one stall-free stretch and one full drain.");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/nhd_pkg.sv
hw/rtl/nhd_in_if.sv
hw/rtl/nhd_out_if.sv
hw/rtl/nhd_in_stage.sv
hw/rtl/nhd_decode.sv
hw/rtl/nhd_out_fifo.sv
hw/rtl/name_hex_escape_decoder_core.sv
hw/rtl/nhd_checker.sv
test/name_hex_escape_decoder_core_test.sv
